// ===== hw/rtl/acc_pkg.sv =====
// ----------------------------------------------------------------------------
// acc_pkg: shared types and constants for the alarm clock core
// Day length, digit steps, action and cursor codes, and the reciprocal
// used to reduce epoch seconds to a time of day.
// ----------------------------------------------------------------------------
package acc_pkg;

  localparam int unsigned SEC_W = 17;

  localparam logic [SEC_W-1:0] DAY_SECONDS = 17'd86400;
  localparam logic [SEC_W-1:0] DAY_LAST    = 17'd86399;

  // alarm digit steps, hours tens down to seconds units
  localparam logic [SEC_W-1:0] STEP_HOUR_TENS = 17'd36000;
  localparam logic [SEC_W-1:0] STEP_HOUR_UNIT = 17'd3600;
  localparam logic [SEC_W-1:0] STEP_MIN_TENS  = 17'd600;
  localparam logic [SEC_W-1:0] STEP_MIN_UNIT  = 17'd60;
  localparam logic [SEC_W-1:0] STEP_SEC_TENS  = 17'd10;
  localparam logic [SEC_W-1:0] STEP_SEC_UNIT  = 17'd1;

  // action codes; the fourth code is unused and changes nothing
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_POLL = 2'd1;
  localparam logic [1:0] ACT_SET  = 2'd2;

  // cursor codes
  localparam logic [2:0] CUR_NONE      = 3'd0;
  localparam logic [2:0] CUR_HOUR_TENS = 3'd1;
  localparam logic [2:0] CUR_HOUR_UNIT = 3'd2;
  localparam logic [2:0] CUR_MIN_TENS  = 3'd3;
  localparam logic [2:0] CUR_MIN_UNIT  = 3'd4;
  localparam logic [2:0] CUR_SEC_TENS  = 3'd5;
  localparam logic [2:0] CUR_SEC_UNIT  = 3'd6;
  localparam logic [2:0] CUR_ENABLE    = 3'd7;

  // held-button bit positions
  localparam logic [1:0] HELD_OK   = 2'd0;
  localparam logic [1:0] HELD_UP   = 2'd1;
  localparam logic [1:0] HELD_DOWN = 2'd2;

  // 86400 = 128 * 675: the low 7 bits pass straight through and the upper
  // 25 bits are reduced modulo 675 by a reciprocal multiply, exact for
  // every 25-bit value with a ceiling reciprocal at shift 35.
  localparam int unsigned LOW_W   = 7;
  localparam int unsigned HIGH_W  = 25;
  localparam int unsigned QUOT_W  = 16;
  localparam int unsigned REM_W   = 10;
  localparam int unsigned RECIP_W = 26;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned PROD_W  = HIGH_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_675 = 26'd50903317;
  localparam logic [REM_W-1:0]   MOD_ODD   = 10'd675;

  typedef struct packed {
    logic [1:0]       action;
    logic             ok_level;
    logic             up_level;
    logic             down_level;
    logic [SEC_W-1:0] tod_set;
  } acc_item_t;

  typedef struct packed {
    logic [SEC_W-1:0] time_of_day;
    logic [SEC_W-1:0] alarm_setting;
    logic [2:0]       cursor;
    logic             enabled;
    logic             active;
  } acc_state_t;

endpackage

// ===== hw/rtl/acc_front.sv =====
// ----------------------------------------------------------------------------
// acc_front: input register and time-of-day reduction pipe
// Registers each accepted word and reduces its epoch seconds modulo 86400
// over two stages, one multiply per stage.
// ----------------------------------------------------------------------------
module acc_front
  import acc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [1:0]      in_action,
  input  logic            in_ok_level,
  input  logic            in_up_level,
  input  logic            in_down_level,
  input  logic [31:0]     in_time_value,
  output logic            item_valid,
  output acc_item_t       item
);

  // stage 1: input register plus reciprocal product
  logic              s1_valid_r;
  logic [1:0]        s1_action_r;
  logic              s1_ok_r, s1_up_r, s1_down_r;
  logic [LOW_W-1:0]  s1_low_r;
  logic [HIGH_W-1:0] s1_high_r;
  logic [QUOT_W-1:0] s1_quot_r;

  // stage 2: finished item
  logic              s2_valid_r;
  acc_item_t         s2_item_r;

  logic [HIGH_W-1:0] high_in;
  logic [PROD_W-1:0] prod;
  logic [HIGH_W:0]   qm;
  logic [HIGH_W:0]   rem_full;
  acc_item_t         s2_nxt;

  assign high_in = in_time_value[31:LOW_W];
  assign prod    = PROD_W'(high_in) * PROD_W'(RECIP_675);

  // remainder of the upper part modulo 675, always below 675
  assign qm       = (HIGH_W+1)'(s1_quot_r) * (HIGH_W+1)'(MOD_ODD);
  assign rem_full = (HIGH_W+1)'(s1_high_r) - qm;

  always_comb begin
    s2_nxt.action     = s1_action_r;
    s2_nxt.ok_level   = s1_ok_r;
    s2_nxt.up_level   = s1_up_r;
    s2_nxt.down_level = s1_down_r;
    s2_nxt.tod_set    = {rem_full[REM_W-1:0], s1_low_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
    if (adv) begin
      s1_action_r <= in_action;
      s1_ok_r     <= in_ok_level;
      s1_up_r     <= in_up_level;
      s1_down_r   <= in_down_level;
      s1_low_r    <= in_time_value[LOW_W-1:0];
      s1_high_r   <= high_in;
      s1_quot_r   <= prod[PROD_W-1:RECIP_SHIFT];
      s2_item_r   <= s2_nxt;
    end
  end

  assign item_valid = s2_valid_r;
  assign item       = s2_item_r;

endmodule

// ===== hw/rtl/acc_core.sv =====
// ----------------------------------------------------------------------------
// acc_core: clock state update and result register
// Applies one tick, poll or set word per cycle while adv is high; the state
// register is the result register.
// ----------------------------------------------------------------------------
module acc_core
  import acc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       item_valid,
  input  acc_item_t  item,
  output logic       out_valid,
  output acc_state_t st
);

  typedef struct packed {
    logic [SEC_W-1:0] alarm;
    logic             en;
  } acc_adj_t;

  function automatic acc_adj_t adjust(input logic [SEC_W-1:0] a, input logic en,
                                      input logic [2:0] cur, input logic up);
    acc_adj_t         res;
    logic [SEC_W-1:0] step;
    logic [SEC_W:0]   sum;
    res.alarm = a;
    res.en    = en;
    step      = '0;
    sum       = '0;
    unique case (cur)
      CUR_HOUR_TENS: step = STEP_HOUR_TENS;
      CUR_HOUR_UNIT: step = STEP_HOUR_UNIT;
      CUR_MIN_TENS:  step = STEP_MIN_TENS;
      CUR_MIN_UNIT:  step = STEP_MIN_UNIT;
      CUR_SEC_TENS:  step = STEP_SEC_TENS;
      CUR_SEC_UNIT:  step = STEP_SEC_UNIT;
      CUR_ENABLE:    res.en = ~en;
      default:       step = '0;
    endcase
    if (step != '0) begin
      if (up) begin
        sum = {1'b0, a} + {1'b0, step};
        res.alarm = (sum >= {1'b0, DAY_SECONDS}) ? SEC_W'(sum - {1'b0, DAY_SECONDS})
                                                 : sum[SEC_W-1:0];
      end else begin
        res.alarm = (a >= step) ? (a - step) : (a + (DAY_SECONDS - step));
      end
    end
    return res;
  endfunction

  acc_state_t st_r, st_nxt;
  logic [2:0] held_r, held_nxt;
  logic       out_valid_r;
  logic       upd;

  logic             ok_new, up_new, dn_new;
  logic [SEC_W-1:0] tod_inc;
  acc_adj_t         adj_up, adj_dn;

  assign upd = adv && item_valid;

  always_comb begin
    st_nxt   = st_r;
    held_nxt = held_r;
    tod_inc  = (st_r.time_of_day == DAY_LAST) ? '0 : st_r.time_of_day + 1'b1;
    ok_new   = !held_r[HELD_OK] && !item.ok_level;
    up_new   = !held_r[HELD_UP] && !item.up_level;
    dn_new   = !held_r[HELD_DOWN] && !item.down_level;
    adj_up   = '0;
    adj_dn   = '0;
    if (upd) begin
      unique case (item.action)
        ACT_TICK: begin
          st_nxt.time_of_day = tod_inc;
          if (tod_inc == st_r.alarm_setting && st_r.enabled) st_nxt.active = 1'b1;
        end
        ACT_POLL: begin
          held_nxt[HELD_OK] = !item.ok_level;
          if (ok_new && st_r.active) begin
            // silence only: up and down are neither acted on nor tracked
            st_nxt.active = 1'b0;
          end else begin
            if (ok_new) st_nxt.cursor = st_r.cursor + 1'b1;
            held_nxt[HELD_UP]   = !item.up_level;
            held_nxt[HELD_DOWN] = !item.down_level;
            adj_up = up_new ? adjust(st_r.alarm_setting, st_r.enabled, st_nxt.cursor, 1'b1)
                            : acc_adj_t'{st_r.alarm_setting, st_r.enabled};
            adj_dn = dn_new ? adjust(adj_up.alarm, adj_up.en, st_nxt.cursor, 1'b0)
                            : adj_up;
            st_nxt.alarm_setting = adj_dn.alarm;
            st_nxt.enabled       = adj_dn.en;
          end
        end
        ACT_SET: st_nxt.time_of_day = item.tod_set;
        default: st_nxt = st_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= item_valid;
      st_r        <= st_nxt;
      held_r      <= held_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign st        = st_r;

  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.time_of_day < DAY_SECONDS && st_r.alarm_setting < DAY_SECONDS)
    else $error("time of day or alarm setting out of range");

  a_ring_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(st_r.active)) |->
      $past(upd && item.action == ACT_TICK && st_r.enabled))
    else $error("alarm raised without an enabled tick");

  a_enable_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && st_r.enabled != $past(st_r.enabled)) |->
      (st_r.cursor == CUR_ENABLE && $past(upd && item.action == ACT_POLL)))
    else $error("enable changed away from the enable position");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(!adv)) |-> ($stable(st_r) && $stable(held_r)))
    else $error("state moved while stalled");

endmodule

// ===== hw/rtl/alarm_clock_controller_core.sv =====
// ----------------------------------------------------------------------------
// alarm_clock_controller_core: time-of-day keeper with alarm and buttons
// Accepts one tick, button poll or set-time word per cycle, unless the
// result side stalls, and returns the updated clock state for every word.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per accepted handshake. in_action selects a second tick,
//           a button poll (active-low ok/up/down levels) or a set-time load
//           of in_time_value (epoch seconds, reduced modulo one day).
//   out_* : one result word per input word, in order: time of day, alarm
//           setting, cursor, enable and ringing flags after the update.
// Pipeline from input acceptance to out_valid: the input register with
//   the reciprocal multiply of the day reduction, the remainder register,
//   then the state register that doubles as the result register.
// Throughput: one word per cycle unless stalled; each word's state update
//   is a single short add/compare/wrap pass, so only a stall holds a word.
// Stall: when out_valid is high and out_ready low the whole pipe holds and
//   in_ready drops; it rises again in the cycle the result is taken.
// Reset: synchronous, active low; clears time, alarm, cursor, flags and the
//   held-button marks, and empties the pipe.
// ----------------------------------------------------------------------------
module alarm_clock_controller_core
  import acc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_action,
  input  logic             in_ok_level,
  input  logic             in_up_level,
  input  logic             in_down_level,
  input  logic [31:0]      in_time_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SEC_W-1:0] out_time_of_day,
  output logic [SEC_W-1:0] out_alarm_setting,
  output logic [2:0]       out_cursor_position,
  output logic             out_alarm_enabled,
  output logic             out_alarm_active
);

  logic       adv;
  logic       item_valid;
  acc_item_t  item;
  acc_state_t st;

  // advance the pipe whenever the result register is empty or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  acc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_valid),
    .in_action     (in_action),
    .in_ok_level   (in_ok_level),
    .in_up_level   (in_up_level),
    .in_down_level (in_down_level),
    .in_time_value (in_time_value),
    .item_valid    (item_valid),
    .item          (item)
  );

  acc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item),
    .out_valid  (out_valid),
    .st         (st)
  );

  // drive the result word straight from the state register
  assign out_time_of_day     = st.time_of_day;
  assign out_alarm_setting   = st.alarm_setting;
  assign out_cursor_position = st.cursor;
  assign out_alarm_enabled   = st.enabled;
  assign out_alarm_active    = st.active;

endmodule

// ===== tb/acc_clock_checker.sv =====
// ----------------------------------------------------------------------------
// acc_clock_checker: result checker for the alarm clock core
// Follows every accepted input word with its own copy of the clock state,
// queues the state each word should report, and compares every accepted
// result word against the oldest queued state.
// ----------------------------------------------------------------------------
module acc_clock_checker
  import acc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       in_action,
  input  logic             in_ok_level,
  input  logic             in_up_level,
  input  logic             in_down_level,
  input  logic [31:0]      in_time_value,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [SEC_W-1:0] out_time_of_day,
  input  logic [SEC_W-1:0] out_alarm_setting,
  input  logic [2:0]       out_cursor_position,
  input  logic             out_alarm_enabled,
  input  logic             out_alarm_active,
  output int unsigned      mismatch_count,
  output int unsigned      words_due
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SHOWN_MAX = 10;

  logic [SEC_W-1:0] pred_tod;
  logic [SEC_W-1:0] pred_alarm;
  logic [2:0]       pred_cursor;
  logic             pred_armed;
  logic             pred_ringing;
  logic [2:0]       pred_held;

  acc_state_t  due_states[$];
  acc_state_t  got;
  acc_state_t  want;
  int unsigned n_bad = 0;

  assign mismatch_count = n_bad;

  // new press: seen low while marked released; mark released when seen high
  function automatic logic take_press(input logic [1:0] idx, input logic level);
    take_press = 1'b0;
    if (pred_held[idx]) begin
      if (level) pred_held[idx] = 1'b0;
    end else if (!level) begin
      pred_held[idx] = 1'b1;
      take_press = 1'b1;
    end
  endfunction

  function automatic void nudge_alarm(input logic raise);
    int unsigned step;
    int unsigned sum;
    step = 0;
    case (pred_cursor)
      CUR_HOUR_TENS: step = 32'(STEP_HOUR_TENS);
      CUR_HOUR_UNIT: step = 32'(STEP_HOUR_UNIT);
      CUR_MIN_TENS:  step = 32'(STEP_MIN_TENS);
      CUR_MIN_UNIT:  step = 32'(STEP_MIN_UNIT);
      CUR_SEC_TENS:  step = 32'(STEP_SEC_TENS);
      CUR_SEC_UNIT:  step = 32'(STEP_SEC_UNIT);
      CUR_ENABLE:    pred_armed = ~pred_armed;
      default: ;
    endcase
    if (step != 0) begin
      if (raise) sum = 32'(pred_alarm) + step;
      else sum = 32'(pred_alarm) + 32'(DAY_SECONDS) - step;
      pred_alarm = SEC_W'(sum % 32'(DAY_SECONDS));
    end
  endfunction

  function automatic void advance_clock(input logic [1:0] act, input logic ok_l,
                                        input logic up_l, input logic down_l,
                                        input logic [31:0] epoch);
    logic ok_new;
    case (act)
      ACT_TICK: begin
        pred_tod = (pred_tod == DAY_LAST) ? '0 : pred_tod + 1'b1;
        if (pred_tod == pred_alarm && pred_armed) pred_ringing = 1'b1;
      end
      ACT_POLL: begin
        ok_new = take_press(HELD_OK, ok_l);
        if (ok_new && pred_ringing) begin
          // silencing press: up and down are left untouched this poll
          pred_ringing = 1'b0;
        end else begin
          if (ok_new) pred_cursor = pred_cursor + 1'b1;
          if (take_press(HELD_UP, up_l)) nudge_alarm(1'b1);
          if (take_press(HELD_DOWN, down_l)) nudge_alarm(1'b0);
        end
      end
      ACT_SET: pred_tod = SEC_W'(epoch % 32'(DAY_SECONDS));
      default: ;
    endcase
  endfunction

  function automatic void note_fault(input string what);
    n_bad++;
    if (n_bad <= SHOWN_MAX) $display("%0t: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pred_tod     = '0;
      pred_alarm   = '0;
      pred_cursor  = CUR_NONE;
      pred_armed   = 1'b0;
      pred_ringing = 1'b0;
      pred_held    = '0;
      due_states.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{time_of_day: out_time_of_day, alarm_setting: out_alarm_setting,
                cursor: out_cursor_position, enabled: out_alarm_enabled,
                active: out_alarm_active};
        if (due_states.size() == 0) begin
          note_fault($sformatf("result word with none due: tod=%0d alarm=%0d cur=%0d",
                               got.time_of_day, got.alarm_setting, got.cursor));
        end else begin
          want = due_states.pop_front();
          if (got.time_of_day !== want.time_of_day ||
              got.alarm_setting !== want.alarm_setting ||
              got.cursor !== want.cursor || got.enabled !== want.enabled ||
              got.active !== want.active) begin
            note_fault($sformatf({"state mismatch: exp tod=%0d alarm=%0d cur=%0d en=%b",
                                  " ring=%b, got tod=%0d alarm=%0d cur=%0d en=%b ring=%b"},
                                 want.time_of_day, want.alarm_setting, want.cursor,
                                 want.enabled, want.active, got.time_of_day,
                                 got.alarm_setting, got.cursor, got.enabled, got.active));
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_clock(in_action, in_ok_level, in_up_level, in_down_level, in_time_value);
        due_states.push_back('{time_of_day: pred_tod, alarm_setting: pred_alarm,
                               cursor: pred_cursor, enabled: pred_armed,
                               active: pred_ringing});
      end
    end
    words_due <= unsigned'(due_states.size());
  end

endmodule

// ===== tb/tb_alarm_clock_controller_core.sv =====
// ----------------------------------------------------------------------------
// tb_alarm_clock_controller_core: testbench for the alarm clock core
// Drives a directed opening run and then random scenes of ticks, button
// press/release pairs, time loads and alarm approaches, with random gaps
// on both channels; a checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb_alarm_clock_controller_core;

  import acc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS = 1550;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned DAY_SPAN_MAX = 49709; // max k with k*86400+86399 in 32 bits
  localparam logic [1:0]  ACT_SPARE    = 2'd3;  // unused action code

  logic             clk;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic [1:0]       in_action     = ACT_TICK;
  logic             in_ok_level   = 1'b1;
  logic             in_up_level   = 1'b1;
  logic             in_down_level = 1'b1;
  logic [31:0]      in_time_value = '0;
  logic             out_valid;
  logic             out_ready     = 1'b0;
  logic [SEC_W-1:0] out_time_of_day;
  logic [SEC_W-1:0] out_alarm_setting;
  logic [2:0]       out_cursor_position;
  logic             out_alarm_enabled;
  logic             out_alarm_active;

  int unsigned      mismatch_count;
  int unsigned      words_due;
  int unsigned      words_sent  = 0;
  int unsigned      cycle_count = 0;
  logic             calm        = 1'b0;
  logic [SEC_W-1:0] seen_alarm  = '0;

  alarm_clock_controller_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_ok_level         (in_ok_level),
    .in_up_level         (in_up_level),
    .in_down_level       (in_down_level),
    .in_time_value       (in_time_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_time_of_day     (out_time_of_day),
    .out_alarm_setting   (out_alarm_setting),
    .out_cursor_position (out_cursor_position),
    .out_alarm_enabled   (out_alarm_enabled),
    .out_alarm_active    (out_alarm_active)
  );

  acc_clock_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_ok_level         (in_ok_level),
    .in_up_level         (in_up_level),
    .in_down_level       (in_down_level),
    .in_time_value       (in_time_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_time_of_day     (out_time_of_day),
    .out_alarm_setting   (out_alarm_setting),
    .out_cursor_position (out_cursor_position),
    .out_alarm_enabled   (out_alarm_enabled),
    .out_alarm_active    (out_alarm_active),
    .mismatch_count      (mismatch_count),
    .words_due           (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abandon the run if it hangs: far beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_alarm_clock_controller_core: errors");
      $finish;
    end
  end

  // Stall the result side in about one cycle of ten, except in the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 10);
  end

  // Keep the last reported alarm setting so alarm approaches can aim at it.
  always @(posedge clk) begin
    if (out_valid && out_ready) seen_alarm <= out_alarm_setting;
  end

  // Present one word and hold it until taken. Valid stays high on return so
  // that the next word can follow back to back; drop it now and then for a gap.
  task automatic push_word(input logic [1:0] act, input logic ok_l, input logic up_l,
                           input logic down_l, input logic [31:0] epoch);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_ok_level   <= ok_l;
    in_up_level   <= up_l;
    in_down_level <= down_l;
    in_time_value <= epoch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (!calm && $urandom_range(0, 99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding result to come back.
  task automatic settle;
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  // Random level bit, used as button filler or as random button levels.
  function automatic logic coin;
    coin = 1'($urandom_range(0, 1));
  endfunction

  initial begin
    int unsigned      scene;
    int unsigned      lead;
    logic [SEC_W-1:0] aim;
    logic [31:0]      epoch;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: action codes, time load extremes, wraps and buttons.
    push_word(ACT_TICK,  1'b1, 1'b1, 1'b1, '0);
    push_word(ACT_SPARE, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);  // unused code holds state
    push_word(ACT_SET,   1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    push_word(ACT_SET,   1'b1, 1'b1, 1'b1, 32'd86399);
    push_word(ACT_TICK,  1'b0, 1'b0, 1'b0, '0);              // midnight wrap
    push_word(ACT_POLL,  1'b1, 1'b0, 1'b0, '0);              // no digit selected
    push_word(ACT_POLL,  1'b1, 1'b1, 1'b1, '0);
    push_word(ACT_POLL,  1'b0, 1'b1, 1'b0, '0);              // cursor 1, wrap below zero
    push_word(ACT_POLL,  1'b1, 1'b0, 1'b1, '0);              // wrap back up to zero
    // Step the cursor up to the seconds-units digit, releasing between presses.
    repeat (5) begin
      push_word(ACT_POLL, 1'b0, 1'b1, 1'b1, '0);
      push_word(ACT_POLL, 1'b1, 1'b1, 1'b1, '0);
    end
    push_word(ACT_POLL,  1'b0, 1'b0, 1'b1, '0);              // cursor 7, arm the alarm
    push_word(ACT_SET,   1'b1, 1'b1, 1'b1, 32'd0);           // load never rings
    push_word(ACT_SET,   1'b1, 1'b1, 1'b1, 32'd86399);
    push_word(ACT_TICK,  1'b1, 1'b1, 1'b1, '0);              // reaches the alarm, rings
    push_word(ACT_POLL,  1'b1, 1'b1, 1'b1, '0);
    push_word(ACT_POLL,  1'b0, 1'b0, 1'b0, '0);              // silence; up/down skipped
    push_word(ACT_POLL,  1'b1, 1'b0, 1'b0, '0);              // up then down both toggle
    push_word(ACT_POLL,  1'b0, 1'b1, 1'b1, '0);              // cursor wraps to none
    push_word(ACT_POLL,  1'b1, 1'b1, 1'b1, '0);

    // Random scenes, mostly well-formed, with a calm stretch in the middle.
    while (words_sent < RANDOM_WORDS + 30) begin
      calm  <= (words_sent >= 500) && (words_sent < 800);
      scene = $urandom_range(0, 99);
      if (scene < 35) begin
        repeat ($urandom_range(1, 6)) push_word(ACT_TICK, coin(), coin(), coin(), $urandom);
      end else if (scene < 70) begin
        // press some buttons, then mostly release them all
        push_word(ACT_POLL, coin(), coin(), coin(), $urandom);
        if ($urandom_range(0, 3) != 0) push_word(ACT_POLL, 1'b1, 1'b1, 1'b1, $urandom);
        else push_word(ACT_POLL, coin(), coin(), coin(), $urandom);
      end else if (scene < 80) begin
        // approach the current alarm setting from a few seconds short
        settle();
        lead  = $urandom_range(1, 3);
        aim   = SEC_W'((32'(seen_alarm) + 32'(DAY_SECONDS) - lead) % 32'(DAY_SECONDS));
        epoch = $urandom_range(0, DAY_SPAN_MAX) * 32'd86400 + 32'(aim);
        push_word(ACT_SET, coin(), coin(), coin(), epoch);
        repeat (lead + $urandom_range(0, 1)) push_word(ACT_TICK, coin(), coin(), coin(), '0);
        if (coin()) begin
          push_word(ACT_POLL, 1'b0, coin(), coin(), '0);
          push_word(ACT_POLL, 1'b1, 1'b1, 1'b1, '0);
        end
      end else if (scene < 90) begin
        case ($urandom_range(0, 3))
          0:       epoch = $urandom;
          1:       epoch = $urandom_range(0, DAY_SPAN_MAX) * 32'd86400;
          2:       epoch = $urandom_range(0, DAY_SPAN_MAX) * 32'd86400 + 32'(DAY_LAST);
          default: epoch = 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
        push_word(ACT_SET, coin(), coin(), coin(), epoch);
      end else begin
        push_word(2'($urandom_range(0, 3)), coin(), coin(), coin(), $urandom);
      end
    end

    // Drain, then give any stray result time to show up.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_alarm_clock_controller_core: clean");
    end else begin
      $display("tb_alarm_clock_controller_core: errors");
    end
    $finish;
  end

endmodule
